// ===== rtl/core/glpf_pkg.sv =====
// Shared types, constants and helpers of the grid local peak finder.
package glpf_pkg;

   localparam int CFG_BITS         = 7;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int PEAK_BITS        = 6;
   localparam int RSP_BITS         = ((2 * PEAK_BITS + 7) / 8) * 8;
   localparam int QUEUE_DEPTH      = 4;
   localparam int DEF_MAX_COLS     = 64;
   localparam int DEF_MAX_ROWS     = 64;
   localparam int DEF_PIXEL_BITS   = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_ROWS = 1'b0,
      CSR_FRAME_COLS = 1'b1
   } csr_index_type;

   // One classified pixel: which of its candidate cells are peaks, and where it sat.
   typedef struct packed {
      logic                 above;
      logic                 left;
      logic                 here;
      logic [PEAK_BITS-1:0] row;
      logic [PEAK_BITS-1:0] col;
   } glpf_entry_type;

   // Last valid index for a frame dimension: zero counts as one, large values saturate.
   function automatic int unsigned dim_last(logic [CFG_BITS-1:0] value, int unsigned max_dim);
      int unsigned v;
      v = int'(value);
      if (v == 0) return 0;
      if (v > max_dim) return max_dim - 1;
      return v - 1;
   endfunction

endpackage

// ===== rtl/core/glpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module glpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/glpf_front.sv =====
// Front end: frame position, line buffer and per-pixel peak classification.
module glpf_front import glpf_pkg::*; #(
   parameter int MAX_COLS   = DEF_MAX_COLS,
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CFG_BITS-1:0]        csr_wdata,
   input  logic                       pix_valid,
   input  logic signed [PIXEL_BITS-1:0] pix_data,
   input  logic                       push_ready,
   output logic                       push_valid,
   output glpf_entry_type             push_data
);

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int WORD_W = 2 * PIXEL_BITS;

   logic [ROW_W-1:0] row_ff, row_in, last_row_ff, last_row_in;
   logic [COL_W-1:0] col_ff, col_in, last_col_ff, last_col_in;

   // Line buffer word of a column: {row above, row before that}.
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] b_fwd_ff, b_fwd_in;
   logic              b_sel_ff, b_sel_in;
   logic signed [PIXEL_BITS-1:0] l1_ff, l1_in, l2_ff, l2_in, p1_ff, p1_in;

   logic                 accept;
   logic [WORD_W-1:0]    rd_data, wr_data, b_cur;
   logic [COL_W-1:0]     rd_addr;
   logic [COL_W:0]       col_p2, last_ext;
   logic signed [PIXEL_BITS-1:0] x, a_up, a_old, b_up;
   logic                 is_last_row, is_last_col, row_nz, col_nz, row_gt1, col_gt1;
   logic                 above_ok, left_ok, here_ok;

   assign accept = pix_valid && push_ready;
   assign x      = pix_data;
   assign a_up   = a_ff[WORD_W-1:PIXEL_BITS];
   assign a_old  = a_ff[PIXEL_BITS-1:0];
   assign b_cur  = b_sel_ff ? rd_data : b_fwd_ff;
   assign b_up   = b_cur[WORD_W-1:PIXEL_BITS];
   assign wr_data = {x, a_up};

   assign is_last_row = (row_ff == last_row_ff);
   assign is_last_col = (col_ff == last_col_ff);
   assign row_nz      = (row_ff != '0);
   assign col_nz      = (col_ff != '0);
   assign row_gt1     = (row_ff > ROW_W'(1));
   assign col_gt1     = (col_ff > COL_W'(1));

   // Cell above is complete once its lower neighbour arrives.
   assign above_ok = row_nz && (a_up >= x) && !(row_gt1 && (a_up < a_old)) &&
                     !(col_nz && (a_up < p1_ff)) && !(!is_last_col && (a_up < b_up));
   // On the last row the cell to the left now has its right neighbour.
   assign left_ok  = is_last_row && col_nz && (l1_ff >= x) &&
                     !(row_nz && (l1_ff < p1_ff)) && !(col_gt1 && (l1_ff < l2_ff));
   // The final cell of the frame is complete on arrival.
   assign here_ok  = is_last_row && is_last_col && !(row_nz && (x < a_up)) &&
                     !(col_nz && (x < l1_ff));

   assign push_valid      = accept && (above_ok || left_ok || here_ok);
   assign push_data.above = above_ok;
   assign push_data.left  = left_ok;
   assign push_data.here  = here_ok;
   assign push_data.row   = PEAK_BITS'(row_ff);
   assign push_data.col   = PEAK_BITS'(col_ff);

   // Prefetch the column two ahead in raster order, wrapping within the frame width.
   always_comb begin
      col_p2   = {1'b0, col_ff} + (COL_W + 1)'(2);
      last_ext = {1'b0, last_col_ff};
      if (last_col_ff == '0) begin
         rd_addr = '0;
      end else if (col_p2 > last_ext) begin
         rd_addr = COL_W'(col_p2 - last_ext - (COL_W + 1)'(1));
      end else begin
         rd_addr = col_p2[COL_W-1:0];
      end
   end

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      last_row_in = last_row_ff;
      last_col_in = last_col_ff;
      a_in        = a_ff;
      b_fwd_in    = b_fwd_ff;
      b_sel_in    = b_sel_ff;
      l1_in       = l1_ff;
      l2_in       = l2_ff;
      p1_in       = p1_ff;
      if (csr_wen) begin
         row_in = '0;
         col_in = '0;
         case (csr_index_type'(csr_index))
            CSR_FRAME_ROWS: last_row_in = ROW_W'(dim_last(csr_wdata, MAX_ROWS));
            CSR_FRAME_COLS: last_col_in = COL_W'(dim_last(csr_wdata, MAX_COLS));
            default: ;
         endcase
      end else if (accept) begin
         l2_in = l1_ff;
         l1_in = x;
         p1_in = a_up;
         // With a single column the next word is the one written right now.
         a_in  = (last_col_ff == '0) ? wr_data : b_cur;
         if (rd_addr == col_ff) begin
            b_sel_in = 1'b0;
            b_fwd_in = wr_data;
         end else begin
            b_sel_in = 1'b1;
         end
         if (is_last_col) begin
            col_in = '0;
            row_in = is_last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         last_row_ff <= '0;
         last_col_ff <= '0;
         b_sel_ff    <= 1'b1;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         last_row_ff <= last_row_in;
         last_col_ff <= last_col_in;
         b_sel_ff    <= b_sel_in;
      end
      a_ff     <= a_in;
      b_fwd_ff <= b_fwd_in;
      l1_ff    <= l1_in;
      l2_ff    <= l2_in;
      p1_ff    <= p1_in;
   end

   glpf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_COLS)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept && !csr_wen),
      .wr_addr (col_ff),
      .wr_data (wr_data),
      .rd_en   (accept && !csr_wen),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== rtl/core/glpf_queue.sv =====
// Short queue of classified pixels between front end and result sequencer.
module glpf_queue import glpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  glpf_entry_type push_data,
   output logic           push_ready,
   output logic           pop_valid,
   input  logic           pop_ready,
   output glpf_entry_type pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   glpf_entry_type   q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/glpf_back.sv =====
// Back end: expands one classified pixel into its peak coordinate beats.
module glpf_back import glpf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  glpf_entry_type       pop_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [PEAK_BITS-1:0] out_row,
   output logic [PEAK_BITS-1:0] out_col,
   output logic                 out_last
);

   glpf_entry_type hold_ff, hold_in;
   logic [2:0]     flags, sel, rest;
   logic           fire;

   assign flags     = {hold_ff.above, hold_ff.left, hold_ff.here};
   assign out_valid = (flags != '0);
   assign fire      = out_valid && out_ready;

   // Cells go out in raster order: above, then left, then the pixel itself.
   always_comb begin
      if (hold_ff.above) begin
         sel     = 3'b100;
         out_row = hold_ff.row - PEAK_BITS'(1);
         out_col = hold_ff.col;
      end else if (hold_ff.left) begin
         sel     = 3'b010;
         out_row = hold_ff.row;
         out_col = hold_ff.col - PEAK_BITS'(1);
      end else begin
         sel     = 3'b001;
         out_row = hold_ff.row;
         out_col = hold_ff.col;
      end
   end

   assign out_last  = ((flags & ~sel) == '0);
   assign rest      = fire ? (flags & ~sel) : flags;
   assign pop_ready = (rest == '0);

   always_comb begin
      hold_in       = hold_ff;
      hold_in.above = rest[2];
      hold_in.left  = rest[1];
      hold_in.here  = rest[0];
      if (pop_ready && pop_valid) begin
         hold_in = pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.above <= 1'b0;
         hold_ff.left  <= 1'b0;
         hold_ff.here  <= 1'b0;
      end else begin
         hold_ff.above <= hold_in.above;
         hold_ff.left  <= hold_in.left;
         hold_ff.here  <= hold_in.here;
      end
      hold_ff.row <= hold_in.row;
      hold_ff.col <= hold_in.col;
   end

endmodule

// ===== rtl/core/grid_local_peak_finder.sv =====
// Top level of the grid local peak finder.
//
// Pixels of a frame arrive in raster order on the req_ stream, one beat per pixel.
// The csr_ port sets the frame size (frame_rows, frame_cols, 1 to MAX_ROWS/MAX_COLS;
// zero counts as one) and restarts the frame at row 0, column 0. Write it while idle.
// Each cell that is not below any existing up, down, left or right neighbour is
// reported on the rsp_ stream as one beat holding its row and column. A cell is
// reported with the pixel that completes its neighbourhood; rsp_tlast marks the
// final beat caused by one pixel, and a pixel may cause none, one, two or three.
// A pixel's classification is written into the queue and then into the result
// sequencer's hold register, from which its first beat turns valid.
// Throughput: one pixel per cycle while req_tready is high; results leave at one
// beat per cycle while rsp_tready is high, so on the last row, where a pixel can
// cause three beats, the result port sets the rate. A four-entry queue sits
// between the pixel classifier and the result sequencer, and req_tready drops while
// it is full, which happens when rsp_tready is held low or when last-row pixels
// arrive faster than their beats can leave. A stalled result beat holds its data.
// Reset clears the frame size to 1 x 1 and the position to the frame start; the
// line buffer holds no valid data until rows have been written into it.
module grid_local_peak_finder import glpf_pkg::*; #(
   parameter int MAX_COLS   = DEF_MAX_COLS,
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CFG_BITS-1:0]               csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]   req_tdata,  // pixel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_BITS-1:0]               rsp_tdata,  // peak_col (high), peak_row (low)
   output logic                              rsp_tlast
);

   glpf_entry_type       push_data, pop_data;
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   logic [PEAK_BITS-1:0] peak_row, peak_col;

   glpf_front #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pix_valid  (req_tvalid),
      .pix_data   (req_tdata[PIXEL_BITS-1:0]),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   glpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   glpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_row   (peak_row),
      .out_col   (peak_col),
      .out_last  (rsp_tlast)
   );

   assign req_tready = push_ready;
   assign rsp_tdata  = {(RSP_BITS - 2 * PEAK_BITS)'(0), peak_col, peak_row};

endmodule

// ===== rtl/core/glpf_checker.sv =====
// Port-level checks of the grid local peak finder, bound to the top level.
module glpf_port_checker import glpf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   // A stalled result beat stays and holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // Nothing is reported right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // Results start flowing only after a pixel beat was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result beat without a pixel beat");

   // Input back-pressure only occurs while a result waits on the output.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("pixel stream stalled with no result pending");

endmodule

bind grid_local_peak_finder glpf_port_checker u_glpf_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
